>>> rtl/psq_pkg.sv
// Shared types and constants for the sorted priority insert queue.
// No dependencies; every other file imports this package.
package psq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TURN_W    = 7;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_LISTED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  sev;
    logic [7:0]  age;
    logic [15:0] arr;
  } entry_t;

  typedef struct packed {
    logic        command;
    logic [15:0] ticket_id;
    logic [7:0]  severity;
    logic [7:0]  age;
    logic [15:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TURN_W-1:0] turn;
    logic [15:0]       out_ticket_id;
    logic [7:0]        out_severity;
    logic [7:0]        out_age;
    logic [15:0]       out_arrival_time;
    logic              last;
  } out_item_t;

endpackage

>>> rtl/psq_mem.sv
// Entry store: one write port and one registered read port.
// Depends on psq_pkg for the entry type.
module psq_mem import psq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/psq_cmp.sv
// Priority comparator shared by every step of the insert scan.
// Depends on psq_pkg for the entry type.
module psq_cmp import psq_pkg::*; (
  input  entry_t cand,
  input  entry_t stored,
  output logic   outranks
);

  // Higher severity, then lower age, then earlier arrival; full tie loses
  always_comb begin
    if (cand.sev != stored.sev) begin
      outranks = cand.sev > stored.sev;
    end else if (cand.age != stored.age) begin
      outranks = cand.age < stored.age;
    end else begin
      outranks = cand.arr < stored.arr;
    end
  end

endmodule

>>> rtl/sorted_priority_insert_queue_core.sv
// Insert: an empty queue takes the entry straight into slot zero; otherwise the scan walks
// down from the tail, one entry per cycle through the single comparator and the one memory
// write port, down to and including the first entry not outranked, or with an extra write
// state (S_IPUT) when the entry lands at the head. A full-queue insert is dropped and an
// empty list reports empty. List: one beat per cycle when the output is not stalled.
// Synchronous reset empties the queue and idles the sequencer; the store is not cleared.
module sorted_priority_insert_queue_core import psq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ICMP  = 3'd2;
  localparam logic [2:0] S_IPUT  = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  in_item_t      item;
  out_item_t     res, res_next;
  out_item_t     out_next;
  logic          load_out;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  entry_t        new_e;
  logic          outranks;
  logic          out_free;

  assign new_e    = '{id: item.ticket_id, sev: item.severity, age: item.age,
                      arr: item.arrival_time};
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  psq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  psq_cmp u_cmp (
    .cand     (new_e),
    .stored   (rd_data),
    .outranks (outranks)
  );

  // Sequencer: dispatch, tail-first scan and shift, list walk
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    res_next   = res;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = new_e;
    load_out   = 1'b0;
    out_next   = res;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        res_next = '{status: ST_INSERTED, turn: '0, out_ticket_id: item.ticket_id,
                     out_severity: item.severity, out_age: item.age,
                     out_arrival_time: item.arrival_time, last: 1'b1};
        if (item.command == CMD_LIST) begin
          if (count == '0) begin
            res_next   = '0;
            res_next.status = ST_EMPTY;
            res_next.last   = 1'b1;
            state_next = S_EMIT;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            idx_next   = '0;
            state_next = S_LIST;
          end
        end else if (count == CW'(DEPTH)) begin
          res_next.status = ST_FULL;
          state_next      = S_EMIT;
        end else if (count == '0) begin
          wr_en         = 1'b1;
          wr_addr       = '0;
          count_next    = CW'(1);
          res_next.turn = TURN_W'(1);
          state_next    = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(count - CW'(1));
          idx_next   = AW'(count - CW'(1));
          state_next = S_ICMP;
        end
      end
      S_ICMP: begin
        wr_en   = 1'b1;
        wr_addr = idx + AW'(1);
        if (outranks) begin
          // shift the stored entry one slot back and keep scanning
          wr_data = rd_data;
          if (idx == '0) begin
            state_next = S_IPUT;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx - AW'(1);
            idx_next = idx - AW'(1);
          end
        end else begin
          count_next    = count + CW'(1);
          res_next.turn = TURN_W'(idx) + TURN_W'(2);
          state_next    = S_EMIT;
        end
      end
      S_IPUT: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        count_next    = count + CW'(1);
        res_next.turn = TURN_W'(1);
        state_next    = S_EMIT;
      end
      S_LIST: begin
        out_next = '{status: ST_LISTED, turn: TURN_W'(idx) + TURN_W'(1),
                     out_ticket_id: rd_data.id, out_severity: rd_data.sev,
                     out_age: rd_data.age, out_arrival_time: rd_data.arr,
                     last: (CW'(idx) + CW'(1)) == count};
        if (out_free) begin
          load_out = 1'b1;
          if ((CW'(idx) + CW'(1)) == count) begin
            state_next = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx + AW'(1);
            idx_next = idx + AW'(1);
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
    idx <= idx_next;
    res <= res_next;
    if (load_out) begin
      out_data <= out_next;
    end
  end

endmodule

>>> rtl/psq_chk.sv
// Port-level checks on the sorted priority insert queue top level.
// Depends on psq_pkg; bound to sorted_priority_insert_queue_core below.
module psq_chk import psq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // Stall the input once a command has been taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in progress");

  // Empty and full results carry no position and end the command
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_EMPTY || out_data.status == ST_FULL)
      |-> out_data.turn == '0 && out_data.last)
    else $error("empty or full result malformed");

  // An insert reports a real position and is the only beat
  a_insert: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_INSERTED
      |-> out_data.turn != '0 && out_data.last)
    else $error("insert result malformed");

endmodule

bind sorted_priority_insert_queue_core psq_chk u_psq_chk (.*);

>>> tb/sv/tb.sv
// Testbench for sorted_priority_insert_queue_core: sends insert and list commands and
// checks every result beat, in order, against a shadow copy of the queue.
// Depends on psq_pkg and the core RTL; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psq_pkg::*;

  localparam int QDEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = QDEPTH + 8;
  localparam int RANDOM_ITEMS = 248;

  logic      clk      = 1'b0;
  logic      rst      = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow of the queue contents and the beats still owed by the core
  entry_t    shadow_slots [QDEPTH];
  int        shadow_count = 0;
  out_item_t awaited_beats [$];

  int fault_count = 0;
  int calm_run    = 0;

  always #6 clk = ~clk;

  sorted_priority_insert_queue_core #(.DEPTH(QDEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // True when a new ticket is served ahead of a stored one
  function automatic bit outranks(input entry_t fresh, input entry_t held);
    if (fresh.sev != held.sev) return fresh.sev > held.sev;
    if (fresh.age != held.age) return fresh.age < held.age;
    return fresh.arr < held.arr;
  endfunction

  function automatic out_item_t make_beat(input logic [1:0] status,
                                          input logic [TURN_W-1:0] turn,
                                          input entry_t e, input logic last);
    out_item_t beat;
    beat.status           = status;
    beat.turn             = turn;
    beat.out_ticket_id    = e.id;
    beat.out_severity     = e.sev;
    beat.out_age          = e.age;
    beat.out_arrival_time = e.arr;
    beat.last             = last;
    return beat;
  endfunction

  function automatic in_item_t make_ticket(input logic cmd, input logic [15:0] id,
                                           input logic [7:0] sev, input logic [7:0] age,
                                           input logic [15:0] arr);
    in_item_t item;
    item.command      = cmd;
    item.ticket_id    = id;
    item.severity     = sev;
    item.age          = age;
    item.arrival_time = arr;
    return item;
  endfunction

  // Update the shadow queue for one accepted command and queue up the beats it owes
  task automatic apply_ticket_command(input in_item_t item);
    entry_t fresh;
    entry_t blank;
    int     slot;
    int     i;
    fresh.id  = item.ticket_id;
    fresh.sev = item.severity;
    fresh.age = item.age;
    fresh.arr = item.arrival_time;
    blank     = '0;
    if (item.command == CMD_LIST) begin
      if (shadow_count == 0) begin
        awaited_beats.push_back(make_beat(ST_EMPTY, '0, blank, 1'b1));
      end else begin
        for (i = 0; i < shadow_count; i++) begin
          awaited_beats.push_back(make_beat(ST_LISTED, TURN_W'(i + 1), shadow_slots[i],
                                            i == shadow_count - 1));
        end
      end
    end else if (shadow_count >= QDEPTH) begin
      awaited_beats.push_back(make_beat(ST_FULL, '0, fresh, 1'b1));
    end else begin
      slot = shadow_count;
      for (i = 0; i < shadow_count; i++) begin
        if (outranks(fresh, shadow_slots[i])) begin
          slot = i;
          break;
        end
      end
      for (i = shadow_count; i > slot; i--) shadow_slots[i] = shadow_slots[i - 1];
      shadow_slots[slot] = fresh;
      shadow_count++;
      awaited_beats.push_back(make_beat(ST_INSERTED, TURN_W'(slot + 1), fresh, 1'b1));
    end
  endtask

  // Mostly no gap or a short one, now and then a long one, and calm stretches of none
  function automatic int idle_gap();
    int roll;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_run = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one beat at the falling edge and hold it until the core takes it
  task automatic send_ticket(input in_item_t item);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    apply_ticket_command(item);
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fault_count++;
    end
  endtask

  // Check each accepted result beat against the oldest one owed
  always @(posedge clk) begin : beat_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual status %0d turn %0d id %0d",
                 $time, out_data.status, out_data.turn, out_data.out_ticket_id);
        fault_count++;
      end else begin
        want = awaited_beats.pop_front();
        compare_field("status", want.status, out_data.status);
        compare_field("turn", want.turn, out_data.turn);
        compare_field("ticket_id", want.out_ticket_id, out_data.out_ticket_id);
        compare_field("severity", want.out_severity, out_data.out_severity);
        compare_field("age", want.out_age, out_data.out_age);
        compare_field("arrival_time", want.out_arrival_time, out_data.out_arrival_time);
        compare_field("last", want.last, out_data.last);
      end
    end
  end

  // Stall the result side in runs: mostly short stalls, a few long ones, free runs mostly short, some long
  initial begin : stall_driver
    int hold_left;
    int roll;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 35) begin
          out_stall = 1'b1;
          hold_left = (roll < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end else begin
          out_stall = 1'b0;
          hold_left = (roll < 85) ? $urandom_range(0, 7) : $urandom_range(30, 80);
        end
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d beats still awaited", cycles,
             awaited_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_empty_list();
    send_ticket(make_ticket(CMD_LIST, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
  endtask

  // Walk each tie-break rule: severity, then age, then arrival, full tie goes behind
  task automatic test_ordering_rules();
    send_ticket(make_ticket(CMD_INSERT, 16'hFFFF, 8'd0,   8'd255, 16'hFFFF));
    send_ticket(make_ticket(CMD_INSERT, 16'h0000, 8'd255, 8'd0,   16'h0000));
    send_ticket(make_ticket(CMD_INSERT, 16'h0101, 8'd128, 8'd10,  16'd100));
    send_ticket(make_ticket(CMD_INSERT, 16'h0202, 8'd128, 8'd5,   16'd200));
    send_ticket(make_ticket(CMD_INSERT, 16'h0303, 8'd128, 8'd5,   16'd50));
    send_ticket(make_ticket(CMD_INSERT, 16'h0404, 8'd128, 8'd5,   16'd50));
    send_ticket(make_ticket(CMD_INSERT, 16'h0505, 8'd0,   8'd255, 16'hFFFF));
    send_ticket(make_ticket(CMD_INSERT, 16'h0606, 8'd128, 8'd200, 16'd0));
    send_ticket(make_ticket(CMD_INSERT, 16'h0707, 8'd128, 8'd10,  16'd101));
    send_ticket(make_ticket(CMD_LIST,   16'h0000, 8'd0,   8'd0,   16'h0000));
  endtask

  // Fill with clustered keys so ties are common, then bounce inserts off the full queue
  task automatic test_fill_and_drop();
    while (shadow_count < QDEPTH) begin
      send_ticket(make_ticket(CMD_INSERT, 16'($urandom), 8'($urandom_range(127, 129)),
                              8'($urandom_range(4, 11)), 16'($urandom_range(48, 52))));
    end
    send_ticket(make_ticket(CMD_LIST,   16'h0000, 8'd0,   8'd0,   16'h0000));
    send_ticket(make_ticket(CMD_INSERT, 16'h0000, 8'd0,   8'd0,   16'h0000));
    send_ticket(make_ticket(CMD_INSERT, 16'hFFFF, 8'hFF,  8'hFF,  16'hFFFF));
    send_ticket(make_ticket(CMD_LIST,   16'hFFFF, 8'hFF,  8'hFF,  16'hFFFF));
  endtask

  // Mix of full-range inserts and lists
  task automatic test_random_traffic();
    logic cmd;
    repeat (RANDOM_ITEMS) begin
      cmd = ($urandom_range(0, 99) < 30) ? CMD_LIST : CMD_INSERT;
      send_ticket(make_ticket(cmd, 16'($urandom), 8'($urandom), 8'($urandom),
                              16'($urandom)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_list();
    test_ordering_rules();
    test_fill_and_drop();
    test_random_traffic();
    @(negedge clk);
    in_valid = 1'b0;
    // Drain the owed beats, then watch for strays
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/psq_pkg.sv
rtl/psq_mem.sv
rtl/psq_cmp.sv
rtl/sorted_priority_insert_queue_core.sv
rtl/psq_chk.sv
tb/sv/tb.sv
